// File: src/periodic_task_timer_table_assert.svh
// ---------------------------------------------------------------------------
// Task timer table assertion macros
// Short forms for the concurrent checks used in the task timer table RTL.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ptt_pkg.sv
// ---------------------------------------------------------------------------
// Task timer table package
// Shared types, field widths and command codes of the task timer table.
// ---------------------------------------------------------------------------
package ptt_pkg;

    localparam int CMD_W   = 2;
    localparam int IDX_W   = 8;
    localparam int DELAY_W = 16;
    localparam int RUN_W   = 8;
    localparam int DISP_W  = 3;
    localparam int MAX_OUT = 8;
    localparam int CNT_W   = 4;

    localparam logic [RUN_W-1:0] RUN_LIMIT = 8'd255;

    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POLL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic               occupied;
        logic               ready;
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] period;
        logic [RUN_W-1:0]   runs;
    } slot_rec_t;

endpackage

// File: src/ptt_cmd_if.sv
// ---------------------------------------------------------------------------
// Task timer table command channel
// Valid/ready channel carrying one command beat.
// ---------------------------------------------------------------------------
interface ptt_cmd_if
    import ptt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [IDX_W-1:0]   slot_index;
    logic               handler_present;
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] period_ticks;
    logic               ready_flag;

    modport source (
        output valid, cmd, slot_index, handler_present, first_delay, period_ticks,
               ready_flag,
        input  ready
    );

    modport sink (
        input  valid, cmd, slot_index, handler_present, first_delay, period_ticks,
               ready_flag,
        output ready
    );
endinterface

// File: src/ptt_res_if.sv
// ---------------------------------------------------------------------------
// Task timer table result channel
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
interface ptt_res_if
    import ptt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              add_rejected;
    logic              dispatch_valid;
    logic [DISP_W-1:0] dispatch_slot;
    logic              last_result;

    modport source (
        output valid, add_rejected, dispatch_valid, dispatch_slot, last_result,
        input  ready
    );

    modport sink (
        input  valid, add_rejected, dispatch_valid, dispatch_slot, last_result,
        output ready
    );
endinterface

// File: src/periodic_task_timer_table.sv
// ---------------------------------------------------------------------------
// Periodic task timer table
// An add beat reads the slot memory, then checks and writes the slot, and
// returns one result. A tick or poll beat sweeps every slot through the
// single slot memory, one slot per cycle unless a poll sweep stalls on the
// result channel; a tick beat returns one result; a poll beat returns one
// result per dispatched slot, at most eight (one if none is dispatched), and
// stops its sweep after the eighth. One command is handled at a time; the
// registered result stage lets the next command beat be taken while the
// last result still waits. Slot state is cleared at reset through per-entry
// valid bits, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module periodic_task_timer_table
    import ptt_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    ptt_cmd_if.sink   req,
    ptt_res_if.source rsp
);

    localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    slot_rec_t         mem_wr_data;
    slot_rec_t         mem_rd_data;

    ptt_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    ptt_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data)
    );

endmodule

// File: src/ptt_slot_mem.sv
// ---------------------------------------------------------------------------
// Task timer slot memory
// One read port and one write port, registered read data, with a valid bit
// per entry so that an entry never written reads as an empty slot.
// ---------------------------------------------------------------------------
module ptt_slot_mem
    import ptt_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int ADDR_W     = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  slot_rec_t         wr_data,
    output slot_rec_t         rd_data
);

    slot_rec_t             slot_mem [SLOT_COUNT];
    slot_rec_t             rd_raw_reg;
    logic                  rd_vld_reg;
    logic [SLOT_COUNT-1:0] vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;

endmodule

// File: src/ptt_ctrl.sv
// ---------------------------------------------------------------------------
// Task timer table controller
// Sequences adds, tick sweeps and poll sweeps over the slot memory and
// drives the registered result channel.
// ---------------------------------------------------------------------------
module ptt_ctrl
    import ptt_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int ADDR_W     = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    ptt_cmd_if.sink           req,
    ptt_res_if.source         rsp,
    output logic              mem_rd_en,
    output logic [ADDR_W-1:0] mem_rd_addr,
    output logic              mem_wr_en,
    output logic [ADDR_W-1:0] mem_wr_addr,
    output slot_rec_t         mem_wr_data,
    input  slot_rec_t         mem_rd_data
);

    state_t              state_reg,      state_next;
    logic                is_poll_reg,    is_poll_next;
    logic [ADDR_W-1:0]   scan_idx_reg,   scan_idx_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [DISP_W-1:0]   hold_slot_reg,  hold_slot_next;
    logic [CNT_W-1:0]    disp_cnt_reg,   disp_cnt_next;
    logic                add_bad_reg,    add_bad_next;
    logic [ADDR_W-1:0]   add_addr_reg,   add_addr_next;
    slot_rec_t           add_rec_reg,    add_rec_next;

    logic                out_valid_reg;
    logic                out_rej_reg;
    logic                out_dv_reg;
    logic [DISP_W-1:0]   out_slot_reg;
    logic                out_last_reg;

    logic                push;
    logic                push_rej;
    logic                push_dv;
    logic [DISP_W-1:0]   push_slot;
    logic                push_last;

    logic                accept;
    logic                out_free;
    logic                in_range;
    logic                active;
    logic                found;
    logic                stall;
    logic                last_slot;
    logic                cap_hit;
    logic [IDX_W-1:0]    scan_idx_wide;
    logic [DISP_W-1:0]   scan_slot;
    slot_rec_t           scan_rec;

    logic                in_scan;
    logic                scan_stall;
    logic                flush_go;
    logic                rw_clash;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_range  = (req.slot_index < IDX_W'(SLOT_COUNT));

    assign scan_idx_wide = IDX_W'(scan_idx_reg);
    assign scan_slot     = scan_idx_wide[DISP_W-1:0];
    assign last_slot     = (scan_idx_reg == ADDR_W'(SLOT_COUNT - 1));

    assign active = mem_rd_data.occupied && mem_rd_data.ready;
    assign found  = is_poll_reg && active && (mem_rd_data.runs != '0);
    // A second dispatch can only move on once the held one has a free output.
    assign stall   = found && hold_valid_reg && !out_free;
    assign cap_hit = found && (disp_cnt_reg == CNT_W'(MAX_OUT - 1));

    // Slot update for the sweep in progress.
    always_comb
    begin
        scan_rec = mem_rd_data;
        if (is_poll_reg)
        begin
            if (found)
            begin
                scan_rec.runs = RUN_W'(mem_rd_data.runs - 1'b1);
            end
        end
        else if (active)
        begin
            if (mem_rd_data.delay == '0)
            begin
                if (mem_rd_data.runs != RUN_LIMIT)
                begin
                    scan_rec.runs = RUN_W'(mem_rd_data.runs + 1'b1);
                end
                if (mem_rd_data.period != '0)
                begin
                    scan_rec.delay = mem_rd_data.period;
                end
            end
            else
            begin
                scan_rec.delay = DELAY_W'(mem_rd_data.delay - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_poll_reg   <= is_poll_next;
        scan_idx_reg  <= scan_idx_next;
        hold_slot_reg <= hold_slot_next;
        disp_cnt_reg  <= disp_cnt_next;
        add_bad_reg   <= add_bad_next;
        add_addr_reg  <= add_addr_next;
        add_rec_reg   <= add_rec_next;
        if (push)
        begin
            out_rej_reg  <= push_rej;
            out_dv_reg   <= push_dv;
            out_slot_reg <= push_slot;
            out_last_reg <= push_last;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        is_poll_next    = is_poll_reg;
        scan_idx_next   = scan_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        disp_cnt_next   = disp_cnt_reg;
        add_bad_next    = add_bad_reg;
        add_addr_next   = add_addr_reg;
        add_rec_next    = add_rec_reg;

        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = scan_idx_reg;
        mem_wr_data = scan_rec;

        push      = 1'b0;
        push_rej  = 1'b0;
        push_dv   = 1'b0;
        push_slot = '0;
        push_last = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.cmd) inside
                        CMD_ADD:
                        begin
                            add_bad_next  = !in_range;
                            add_addr_next = req.slot_index[ADDR_W-1:0];
                            add_rec_next  = '{occupied: req.handler_present,
                                              ready:    req.ready_flag,
                                              delay:    req.first_delay,
                                              period:   req.period_ticks,
                                              runs:     '0};
                            mem_rd_en     = in_range;
                            mem_rd_addr   = req.slot_index[ADDR_W-1:0];
                            state_next    = ST_ADD;
                        end
                        CMD_TICK, CMD_POLL:
                        begin
                            is_poll_next    = (req.cmd == CMD_POLL);
                            scan_idx_next   = '0;
                            disp_cnt_next   = '0;
                            hold_valid_next = 1'b0;
                            mem_rd_en       = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    push_rej    = add_bad_reg || mem_rd_data.occupied;
                    push_last   = 1'b1;
                    mem_wr_en   = !push_rej;
                    mem_wr_addr = add_addr_reg;
                    mem_wr_data = add_rec_reg;
                    state_next  = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (!stall)
                begin
                    mem_wr_en = 1'b1;
                    if (found)
                    begin
                        // The previously held dispatch is known not to be the last.
                        if (hold_valid_reg)
                        begin
                            push      = 1'b1;
                            push_dv   = 1'b1;
                            push_slot = hold_slot_reg;
                        end
                        hold_valid_next = 1'b1;
                        hold_slot_next  = scan_slot;
                        disp_cnt_next   = CNT_W'(disp_cnt_reg + 1'b1);
                    end
                    if (last_slot || cap_hit)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        mem_rd_en     = 1'b1;
                        mem_rd_addr   = ADDR_W'(scan_idx_reg + 1'b1);
                        scan_idx_next = ADDR_W'(scan_idx_reg + 1'b1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    push            = 1'b1;
                    push_dv         = hold_valid_reg;
                    push_slot       = hold_valid_reg ? hold_slot_reg : '0;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.add_rejected   = out_rej_reg;
    assign rsp.dispatch_valid = out_dv_reg;
    assign rsp.dispatch_slot  = out_slot_reg;
    assign rsp.last_result    = out_last_reg;

    assign in_scan    = (state_reg == ST_SCAN);
    assign scan_stall = in_scan && stall;
    assign flush_go   = (state_reg == ST_FLUSH) && out_free;
    assign rw_clash   = mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr);

`include "periodic_task_timer_table_assert.svh"

    `PTT_ASSERT(a_idle_no_hold, (state_reg == ST_IDLE) |-> !hold_valid_reg, "hold set while idle")
    `PTT_ASSERT(a_no_rw_clash, !rw_clash, "slot read and written together")
    `PTT_ASSERT(a_disp_cap, in_scan |-> (disp_cnt_reg < CNT_W'(MAX_OUT)), "dispatch cap passed")
    `PTT_ASSERT_NEXT(a_flush_done, flush_go, state_reg == ST_IDLE, "flush did not complete")
    `PTT_ASSERT_NEXT(a_stall_holds, scan_stall, $stable(scan_idx_reg), "sweep moved in a stall")
    `PTT_ASSERT_NEXT(a_stall_keeps, scan_stall, hold_valid_reg, "held dispatch lost in a stall")

endmodule
